// ===== src/mono_bitmap_span_fill_unit_defines.svh =====
// Assertion macros for the span fill unit.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef MONO_BITMAP_SPAN_FILL_UNIT_DEFINES_SVH
`define MONO_BITMAP_SPAN_FILL_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define MBSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define MBSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mbsf_pkg.sv =====
// Shared types and constants of the span fill unit.
// No dependencies; every other file but the assertion macro header imports this package.
package mbsf_pkg;

  localparam int SCREEN_BYTES_DEF = 8192;
  localparam int MAX_ROW_BYTES    = 128;
  localparam int FIFO_DEPTH       = 4;
  localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);

  localparam int X_W      = 10;
  localparam int ROW_W    = 13;
  localparam int IDX_W    = 13;
  localparam int RB_W     = 8;
  localparam int DATA_W   = 8;
  localparam int ADDR_MAX_W = 16;

  localparam logic [RB_W-1:0] ROW_BYTES_RST = 8'd2;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef enum logic [1:0] {
    CMD_DRAW,
    CMD_READ,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [ADDR_MAX_W-1:0]   first;
    logic [ADDR_MAX_W-1:0]   last;
    logic [DATA_W-1:0]       lmask;
    logic [DATA_W-1:0]       rmask;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_CHECK
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_RD,
    B_MOD,
    B_FILL,
    B_OUT
  } back_state_t;

endpackage

// ===== src/mbsf_if.sv =====
// Channel interfaces of the span fill unit: input items, result items, configuration.
// Depends on mbsf_pkg for the field widths.
interface mbsf_in_if;
  import mbsf_pkg::*;
  logic             valid;
  logic             ready;
  logic [0:0]       opcode;
  logic [X_W-1:0]   x_start;
  logic [X_W-1:0]   x_end;
  logic [ROW_W-1:0] row;
  logic [IDX_W-1:0] byte_index;
  modport source (output valid, opcode, x_start, x_end, row, byte_index, input ready);
  modport sink   (input valid, opcode, x_start, x_end, row, byte_index, output ready);
endinterface

interface mbsf_out_if;
  import mbsf_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [0:0]        status;
  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

interface mbsf_cfg_if;
  import mbsf_pkg::*;
  logic            valid;
  logic            ready;
  logic [RB_W-1:0] row_bytes;
  modport source (output valid, row_bytes, input ready);
  modport sink   (input valid, row_bytes, output ready);
endinterface

// ===== src/mbsf_fifo.sv =====
// Short command queue between the front and the back of the span fill unit.
// Depends on mbsf_pkg for cmd_t and the queue depth.
module mbsf_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mbsf_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output mbsf_pkg::cmd_t head
);
  import mbsf_pkg::*;

  cmd_t                  slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_PTR_W:0]   count_r, count_nxt;

  assign full  = (count_r == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== src/mbsf_front.sv =====
// Front end of the span fill unit: accepts items, checks them, builds commands.
// Depends on mbsf_pkg and the input channel interface.
module mbsf_front #(
  parameter int SCREEN_BYTES = mbsf_pkg::SCREEN_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  mbsf_in_if.sink                   in_chan,
  input  logic [mbsf_pkg::RB_W-1:0] row_bytes,
  input  logic                      clear_busy,
  input  logic                      fifo_full,
  output logic                      push,
  output mbsf_pkg::cmd_t            push_cmd
);
  import mbsf_pkg::*;

  localparam int PROD_W = ROW_W + RB_W;
  localparam int SUM_W  = PROD_W + 1;

  front_state_t     state_r, state_nxt;
  logic             opcode_r;
  logic [X_W-1:0]   xs_r, xe_r;
  logic [ROW_W-1:0] row_r;
  logic [IDX_W-1:0] idx_r;
  logic [PROD_W-1:0] prod_r;

  logic              rb_bad, span_bad, row_bad, read_bad;
  logic [SUM_W-1:0]  row_end;
  logic [PROD_W-1:0] first_full, last_full;

  assign in_chan.ready = (state_r == F_IDLE) && !clear_busy;

  // Checks and addresses use the product registered in the step before.
  always_comb begin
    rb_bad     = (row_bytes == '0) || ({3'b000, row_bytes} > 11'(MAX_ROW_BYTES));
    span_bad   = (xs_r > xe_r) || ({1'b0, xe_r} >= {row_bytes, 3'b000});
    row_end    = {1'b0, prod_r} + SUM_W'(row_bytes);
    row_bad    = row_end > SUM_W'(SCREEN_BYTES);
    read_bad   = SUM_W'(idx_r) >= SUM_W'(SCREEN_BYTES);
    first_full = prod_r + PROD_W'(xs_r[X_W-1:3]);
    last_full  = prod_r + PROD_W'(xe_r[X_W-1:3]);

    push_cmd.lmask = 8'hFF >> xs_r[2:0];
    push_cmd.rmask = 8'hFF << (3'd7 - xe_r[2:0]);
    push_cmd.last  = last_full[ADDR_MAX_W-1:0];
    if (opcode_r == OP_READ) begin
      push_cmd.kind  = read_bad ? CMD_REJECT : CMD_READ;
      push_cmd.first = ADDR_MAX_W'(idx_r);
    end else begin
      push_cmd.kind  = (rb_bad || span_bad || row_bad) ? CMD_REJECT : CMD_DRAW;
      push_cmd.first = first_full[ADDR_MAX_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    push      = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (in_chan.valid && in_chan.ready) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        state_nxt = F_CHECK;
      end
      F_CHECK: begin
        if (!fifo_full) begin
          push      = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      opcode_r <= in_chan.opcode;
      xs_r     <= in_chan.x_start;
      xe_r     <= in_chan.x_end;
      row_r    <= in_chan.row;
      idx_r    <= in_chan.byte_index;
    end
    if (state_r == F_MUL) begin
      prod_r <= PROD_W'(row_r) * PROD_W'(row_bytes);
    end
  end

endmodule

// ===== src/mbsf_back.sv =====
// Back end of the span fill unit: frame store, span writer and result register.
// Depends on mbsf_pkg and the result channel interface.
module mbsf_back #(
  parameter int SCREEN_BYTES = mbsf_pkg::SCREEN_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fifo_empty,
  input  mbsf_pkg::cmd_t head,
  output logic           pop,
  output logic           clear_busy,
  mbsf_out_if.source     out_chan
);
  import mbsf_pkg::*;

  localparam int ADDR_W = $clog2(SCREEN_BYTES);

  logic [DATA_W-1:0] mem [SCREEN_BYTES];
  logic [DATA_W-1:0] rd_data_r;

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic              last_phase_r, last_phase_nxt;
  logic [DATA_W-1:0] res_data_r, res_data_nxt;
  logic              res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_status_r, out_status_nxt;

  logic              we;
  logic [ADDR_W-1:0] wa, ra, first_a, last_a;
  logic [DATA_W-1:0] wd;

  assign first_a    = cmd_r.first[ADDR_W-1:0];
  assign last_a     = cmd_r.last[ADDR_W-1:0];
  assign ra         = last_phase_r ? last_a : first_a;
  assign clear_busy = (state_r == B_CLEAR);

  assign out_chan.valid     = out_valid_r;
  assign out_chan.read_data = out_data_r;
  assign out_chan.status    = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    cursor_nxt     = cursor_r;
    last_phase_nxt = last_phase_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    we             = 1'b0;
    wa             = cursor_r;
    wd             = '0;
    pop            = 1'b0;
    case (state_r)
      B_CLEAR: begin
        we = 1'b1;
        if (cursor_r == ADDR_W'(SCREEN_BYTES - 1)) begin
          cursor_nxt = '0;
          state_nxt  = B_IDLE;
        end else begin
          cursor_nxt = cursor_r + 1'b1;
        end
      end
      B_IDLE: begin
        if (!fifo_empty) begin
          pop            = 1'b1;
          cmd_nxt        = head;
          last_phase_nxt = 1'b0;
          if (head.kind == CMD_REJECT) begin
            res_data_nxt   = '0;
            res_status_nxt = STATUS_BAD;
            state_nxt      = B_OUT;
          end else begin
            state_nxt = B_RD;
          end
        end
      end
      B_RD: begin
        state_nxt = B_MOD;
      end
      B_MOD: begin
        res_status_nxt = STATUS_OK;
        res_data_nxt   = '0;
        if (cmd_r.kind == CMD_READ) begin
          res_data_nxt = rd_data_r;
          state_nxt    = B_OUT;
        end else if (last_phase_r) begin
          we        = 1'b1;
          wa        = last_a;
          wd        = rd_data_r | cmd_r.rmask;
          state_nxt = B_OUT;
        end else begin
          we = 1'b1;
          wa = first_a;
          if (first_a == last_a) begin
            wd        = rd_data_r | (cmd_r.lmask & cmd_r.rmask);
            state_nxt = B_OUT;
          end else begin
            wd         = rd_data_r | cmd_r.lmask;
            cursor_nxt = first_a + 1'b1;
            state_nxt  = B_FILL;
          end
        end
      end
      B_FILL: begin
        if (cursor_r == last_a) begin
          last_phase_nxt = 1'b1;
          state_nxt      = B_RD;
        end else begin
          we         = 1'b1;
          wd         = 8'hFF;
          cursor_nxt = cursor_r + 1'b1;
        end
      end
      B_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_status_nxt = res_status_r;
          state_nxt      = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_CLEAR;
      cursor_r     <= '0;
      last_phase_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cursor_r     <= cursor_nxt;
      last_phase_r <= last_phase_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

endmodule

// ===== src/mono_bitmap_span_fill_unit.sv =====
// Top level of the monochrome bitmap span fill unit.
// Depends on mbsf_pkg, the channel interfaces, mbsf_front, mbsf_fifo, mbsf_back and the macro header.
//
// This block keeps a one-bit-per-pixel frame buffer of SCREEN_BYTES bytes, leftmost
// pixel in bit 7, and draws horizontal spans into it or reads single bytes back.
// Every item gives exactly one result. After reset the buffer is cleared by a pass
// that writes one byte a cycle, so no item is taken until the pass is done;
// configuration writes are taken at any time. A read, or a draw that stays inside
// one byte, passes through the read, modify and result states, and a rejected item
// goes straight to the result state. A wider draw, up to a full row of 128 bytes,
// modifies its first byte, fills the bytes between and modifies its last byte:
// the frame store has one write port, so the span is written one byte per cycle,
// with a read-modify-write at each edge byte. The front end checks the next item
// and queues it while the back end is still writing, so checking overlaps filling.
`include "mono_bitmap_span_fill_unit_defines.svh"

module mono_bitmap_span_fill_unit #(
  parameter int SCREEN_BYTES = mbsf_pkg::SCREEN_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mbsf_cfg_if.sink    cfg_chan,
  mbsf_in_if.sink     in_chan,
  mbsf_out_if.source  out_chan
);
  import mbsf_pkg::*;

  // Row width register. The user must see that it is only written while the unit is idle,
  // so the front end may read it directly while checking an item; the block does not enforce this.
  logic [RB_W-1:0] row_bytes_r;

  logic clear_busy;
  logic fifo_push, fifo_pop, fifo_full, fifo_empty;
  cmd_t push_cmd, head_cmd;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= ROW_BYTES_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      row_bytes_r <= cfg_chan.row_bytes;
    end
  end

  // The front end accepts items, multiplies out the row base address, checks the
  // coordinates and turns each item into a draw, read or reject command.
  mbsf_front #(
    .SCREEN_BYTES (SCREEN_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .row_bytes  (row_bytes_r),
    .clear_busy (clear_busy),
    .fifo_full  (fifo_full),
    .push       (fifo_push),
    .push_cmd   (push_cmd)
  );

  // A few commands can wait here while the back end is busy with a long span.
  mbsf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_cmd (push_cmd),
    .pop      (fifo_pop),
    .full     (fifo_full),
    .empty    (fifo_empty),
    .head     (head_cmd)
  );

  // The back end owns the frame store, runs the clearing pass, executes commands
  // and holds the result in an output register until it is taken.
  mbsf_back #(
    .SCREEN_BYTES (SCREEN_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .head       (head_cmd),
    .pop        (fifo_pop),
    .clear_busy (clear_busy),
    .out_chan   (out_chan)
  );

  // The clearing pass must start as soon as reset is released.
  `MBSF_ASSERT_IMP(a_clear_after_reset, $rose(rst_n), clear_busy, "clear pass not running")
  // No result may appear before the buffer is cleared.
  `MBSF_ASSERT_IMP(a_no_result_in_clear, clear_busy, !out_chan.valid, "result during clear")
  // The front end must never push into a full queue.
  `MBSF_ASSERT_IMP(a_push_not_full, fifo_push, !fifo_full, "push into full queue")
  // A pushed command is held in the queue at least until the next cycle.
  `MBSF_ASSERT_NXT(a_push_lands, fifo_push, !fifo_empty, "pushed command lost")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for mono_bitmap_span_fill_unit: draws spans and reads bytes back.
// Depends on mbsf_pkg, the channel interfaces in mbsf_if.sv and the unit's RTL.
module tb_top;
  import mbsf_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 20;
  localparam int TOUCH_KEEP  = 64;

  // One input item as the sender sees it.
  typedef struct {
    logic [0:0]       opcode;
    logic [X_W-1:0]   x_start;
    logic [X_W-1:0]   x_end;
    logic [ROW_W-1:0] row;
    logic [IDX_W-1:0] byte_index;
  } span_item_t;

  // One result item: the byte read back and the accept/reject status.
  typedef struct {
    logic [DATA_W-1:0] read_data;
    logic [0:0]        status;
  } span_result_t;

  // Ways in which a random draw is deliberately malformed.
  typedef enum {
    BRK_REVERSED,
    BRK_PAST_END,
    BRK_PAST_BUFFER
  } broken_kind_t;

  logic clk;
  logic rst_n;

  mbsf_in_if  in_if ();
  mbsf_out_if out_if ();
  mbsf_cfg_if cfg_if ();

  mono_bitmap_span_fill_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_if),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Shadow copy of the frame buffer and of the row width register.
  logic [DATA_W-1:0] frame_copy [SCREEN_BYTES_DEF];
  int unsigned       shadow_row_bytes;

  // Results owed by the block, oldest first, and addresses that recent draws hit.
  span_result_t owed_results [$];
  int unsigned  touched_bytes [$];

  int fail_count;
  int results_checked;
  int draws_sent;
  int draws_rejected;
  int reads_sent;
  int cfg_writes;
  int in_stall_cycles;

  // Sender pacing: when pace_on is set, items go out in bursts with gaps between them.
  bit pace_on;
  int burst_left;

  // Receiver state. A long hold-off is requested by bumping hold_tag.
  int       hold_tag;
  int       hold_ack;
  int       hold_left;
  int       rx_count;
  bit [7:0] rx_pattern;

  always #CLK_HALF clk = ~clk;

  // Every input of the block is known from time zero. The frame copy starts cleared,
  // matching the clearing pass that the unit runs after reset.
  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.opcode       = OP_DRAW;
    in_if.x_start      = '0;
    in_if.x_end        = '0;
    in_if.row          = '0;
    in_if.byte_index   = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.row_bytes   = '0;
    shadow_row_bytes   = ROW_BYTES_RST;
    for (int i = 0; i < SCREEN_BYTES_DEF; i++) frame_copy[i] = '0;
  end

  // Applies one accepted item to the frame copy and returns the result it must produce.
  // A draw is legal only with a sane row width, an ordered span inside the row, and a
  // row that lies wholly in the buffer; otherwise it is rejected and changes nothing.
  function automatic span_result_t frame_apply(span_item_t it);
    span_result_t res;
    int unsigned  rb;
    int unsigned  xs;
    int unsigned  xe;
    int unsigned  row;
    int unsigned  first;
    int unsigned  last;
    logic [7:0]   lmask;
    logic [7:0]   rmask;
    rb  = shadow_row_bytes;
    xs  = it.x_start;
    xe  = it.x_end;
    row = it.row;
    res.read_data = '0;
    res.status    = STATUS_OK;
    if (it.opcode == OP_DRAW) begin
      draws_sent++;
      if (rb == 0 || rb > MAX_ROW_BYTES || xs > xe || xe >= rb * 8 ||
          (row + 1) * rb > SCREEN_BYTES_DEF) begin
        res.status = STATUS_BAD;
        draws_rejected++;
      end else begin
        first = row * rb + (xs >> 3);
        last  = row * rb + (xe >> 3);
        lmask = 8'hFF >> (xs % 8);
        rmask = 8'hFF << (7 - (xe % 8));
        if (first == last) begin
          frame_copy[first] |= lmask & rmask;
        end else begin
          frame_copy[first] |= lmask;
          for (int unsigned a = first + 1; a < last; a++) frame_copy[a] = 8'hFF;
          frame_copy[last] |= rmask;
        end
        touched_bytes.push_back(first);
        touched_bytes.push_back(last);
        while (touched_bytes.size() > TOUCH_KEEP) void'(touched_bytes.pop_front());
      end
    end else begin
      reads_sent++;
      if (it.byte_index < SCREEN_BYTES_DEF) begin
        res.read_data = frame_copy[it.byte_index];
      end else begin
        res.status = STATUS_BAD;
      end
    end
    return res;
  endfunction

  function automatic span_item_t mk_draw(int unsigned xs, int unsigned xe, int unsigned row);
    span_item_t it;
    it.opcode     = OP_DRAW;
    it.x_start    = X_W'(xs);
    it.x_end      = X_W'(xe);
    it.row        = ROW_W'(row);
    it.byte_index = IDX_W'($urandom);
    return it;
  endfunction

  function automatic span_item_t mk_read(int unsigned idx);
    span_item_t it;
    it.opcode     = OP_READ;
    it.x_start    = X_W'($urandom);
    it.x_end      = X_W'($urandom);
    it.row        = ROW_W'($urandom);
    it.byte_index = IDX_W'(idx);
    return it;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    $display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    fail_count++;
  endtask

  // Between items the sender may pause. Lowering valid happens only when a gap
  // really follows, so a back-to-back item never sees valid dropped and raised in
  // the same time step.
  task automatic pace_sender();
    int gap;
    if (!pace_on) return;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Offers one item and holds it until the block takes it. The expected result is
  // worked out at the accepting edge, so the frame copy sees items in block order.
  task automatic send_item(span_item_t it);
    in_if.valid      <= 1'b1;
    in_if.opcode     <= it.opcode;
    in_if.x_start    <= it.x_start;
    in_if.x_end      <= it.x_end;
    in_if.row        <= it.row;
    in_if.byte_index <= it.byte_index;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    owed_results.push_back(frame_apply(it));
    pace_sender();
  endtask

  // Returns once every owed result has arrived and the block has had time to settle.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // The row width is only changed while the block is idle.
  task automatic set_row_bytes(int unsigned value);
    wait_drained();
    cfg_if.valid     <= 1'b1;
    cfg_if.row_bytes <= RB_W'(value);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid     <= 1'b0;
    shadow_row_bytes = value & 8'hFF;
    cfg_writes++;
  endtask

  // Builds one random item for the current row width. Most draws are legal spans so
  // the fill path is exercised in depth; some are malformed on purpose, and a few
  // items, or all of them at an unusable row width, are pure noise with every field random.
  function automatic span_item_t random_item();
    span_item_t   it;
    int unsigned  rb;
    int unsigned  width;
    int unsigned  max_row;
    int unsigned  xs;
    int unsigned  xe;
    int unsigned  pick;
    broken_kind_t brk;
    rb   = shadow_row_bytes;
    pick = $urandom_range(0, 99);
    if (pick < 10 || rb == 0 || rb > MAX_ROW_BYTES) begin
      it.opcode     = 1'($urandom);
      it.x_start    = X_W'($urandom);
      it.x_end      = X_W'($urandom);
      it.row        = ROW_W'($urandom);
      it.byte_index = IDX_W'($urandom);
      return it;
    end
    width   = rb * 8;
    max_row = SCREEN_BYTES_DEF / rb - 1;
    if (pick < 45) begin
      // Reads mostly land near bytes that recent draws changed.
      if (touched_bytes.size() != 0 && $urandom_range(0, 9) < 6) begin
        xs = touched_bytes[$urandom_range(0, touched_bytes.size() - 1)];
        xs = xs + $urandom_range(0, 3);
        if (xs >= SCREEN_BYTES_DEF) xs = SCREEN_BYTES_DEF - 1;
        return mk_read(xs);
      end
      return mk_read($urandom_range(0, SCREEN_BYTES_DEF - 1));
    end
    xs = $urandom_range(0, width - 1);
    if ($urandom_range(0, 1) == 0) begin
      xe = xs + $urandom_range(0, 20);
      if (xe >= width) xe = width - 1;
    end else begin
      xe = $urandom_range(xs, width - 1);
    end
    it = mk_draw(xs, xe, $urandom_range(0, max_row));
    if (pick >= 85) begin
      brk = broken_kind_t'($urandom_range(0, 2));
      case (brk)
        BRK_REVERSED: begin
          if (xs != xe) begin
            it.x_start = X_W'(xe);
            it.x_end   = X_W'(xs);
          end else begin
            it.x_start = X_W'(xs + 1);
            it.x_end   = X_W'(xs);
            if (xs == width - 1) it.x_start = X_W'(xs);
          end
        end
        BRK_PAST_END: begin
          if (width < 1024) it.x_end = X_W'($urandom_range(width, 1023));
        end
        BRK_PAST_BUFFER: begin
          if (max_row < (1 << ROW_W) - 1)
            it.row = ROW_W'($urandom_range(max_row + 1, (1 << ROW_W) - 1));
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  // Receiver: stalls on a rotating pattern that is redrawn when its counter runs out,
  // sometimes all ones so that stretches without stalls occur, and on request holds off
  // for a long stretch so that the unit's queue fills and it stops taking items.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_ack     = 0;
      hold_left    = 0;
      rx_count     = 0;
      rx_pattern   = 8'hFF;
    end else begin
      if (hold_ack != hold_tag) begin
        hold_ack  = hold_tag;
        hold_left = HOLD_CYCLES;
      end
      if (rx_count == 0) begin
        rx_count = 64;
        if ($urandom_range(0, 3) == 0) rx_pattern = 8'hFF;
        else rx_pattern = 8'($urandom) | 8'h01;
      end else begin
        rx_count--;
      end
      rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= rx_pattern[0];
      end
    end
  end

  // Result checker: every accepted result is matched field by field against the
  // oldest owed result. A result with nothing owed is itself a failure.
  always @(posedge clk) begin : result_check
    span_result_t want;
    if (rst_n && in_if.valid && !in_if.ready) in_stall_cycles++;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result, status", 0, out_if.status);
      end else begin
        want = owed_results.pop_front();
        if (out_if.read_data !== want.read_data)
          report_mismatch("read_data", want.read_data, out_if.read_data);
        if (out_if.status !== want.status)
          report_mismatch("status", want.status, out_if.status);
        results_checked++;
      end
    end
  end

  // Directed checks at the reset row width of two bytes (16 pixels, 4096 rows):
  // a full row, a span inside one byte, a single pixel, a span crossing a byte
  // boundary, and each kind of rejected draw, with reads to see what landed.
  task automatic test_reset_width();
    send_item(mk_draw(0, 15, 0));
    send_item(mk_read(0));
    send_item(mk_read(1));
    send_item(mk_draw(3, 5, 1));
    send_item(mk_read(2));
    send_item(mk_draw(15, 15, 2));
    send_item(mk_read(5));
    send_item(mk_draw(9, 8, 3));
    send_item(mk_read(7));
    send_item(mk_draw(0, 16, 4));
    send_item(mk_draw(0, 1023, 4));
    send_item(mk_draw(0, 0, 4095));
    send_item(mk_draw(7, 8, 4096));
    send_item(mk_read(8190));
    send_item(mk_read(8191));
    send_item(mk_draw(7, 8, 10));
    send_item(mk_read(20));
    send_item(mk_read(21));
  endtask

  // Width extremes: the widest row, the narrowest row, and widths that disable
  // drawing altogether while reads keep working.
  task automatic test_width_extremes();
    set_row_bytes(MAX_ROW_BYTES);
    send_item(mk_draw(0, 1023, 63));
    send_item(mk_read(8191));
    send_item(mk_draw(0, 0, 64));
    set_row_bytes(1);
    send_item(mk_draw(0, 7, 8191));
    send_item(mk_draw(2, 4, 100));
    send_item(mk_read(100));
    send_item(mk_draw(0, 8, 0));
    set_row_bytes(0);
    send_item(mk_draw(0, 0, 0));
    send_item(mk_read(100));
    set_row_bytes(255);
    send_item(mk_draw(0, 7, 0));
    send_item(mk_read(8191));
  endtask

  // Random phases over a spread of row widths, each with its own sender pacing.
  task automatic test_random_spans();
    int unsigned widths [12];
    widths = '{1, 3, 8, 128, 17, 64, 2, 0, 33, 129, 5, 128};
    widths[10] = $urandom_range(1, MAX_ROW_BYTES);
    foreach (widths[p]) begin
      set_row_bytes(widths[p]);
      pace_on    = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(1, 12);
      repeat (42) send_item(random_item());
    end
  endtask

  // Back-pressure: the receiver holds off for a long stretch while the sender keeps
  // offering items back to back, so the unit's queue fills and its input stalls.
  task automatic test_back_pressure();
    set_row_bytes(16);
    pace_on = 1'b0;
    hold_tag <= hold_tag + 1;
    repeat (24) send_item(random_item());
  endtask

  initial begin
    fail_count      = 0;
    results_checked = 0;
    draws_sent      = 0;
    draws_rejected  = 0;
    reads_sent      = 0;
    cfg_writes      = 0;
    in_stall_cycles = 0;
    hold_tag        = 0;
    pace_on         = 1'b1;
    burst_left      = 4;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first item waits out the clearing pass through the input handshake.
    test_reset_width();
    test_width_extremes();
    test_random_spans();
    test_back_pressure();
    wait_drained();

    $display("Checked %0d results: %0d draws (%0d rejected), %0d reads, %0d width writes.",
             results_checked, draws_sent, draws_rejected, reads_sent, cfg_writes);
    $display("Input was held off for %0d cycles by a full unit or a busy back end.",
             in_stall_cycles);
    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("mono_bitmap_span_fill_unit verification clean");
    end else begin
      $display("mono_bitmap_span_fill_unit verification failed");
    end
    $finish;
  end

  // Watchdog: a run that has not finished by this delay is reported as failed.
  initial begin
    #5_000_000;
    $display("mono_bitmap_span_fill_unit verification failed");
    $finish;
  end

endmodule

// ===== mono_bitmap_span_fill_unit.f =====
+incdir+src
src/mbsf_pkg.sv
src/mbsf_if.sv
src/mbsf_fifo.sv
src/mbsf_front.sv
src/mbsf_back.sv
src/mono_bitmap_span_fill_unit.sv
tb/tb_top.sv
